>>> rtl/krt_pkg.sv
// Shared constants and types for the keyed record table.
`default_nettype none

package krt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PAY_WORDS   = 7;
    localparam int WORD_W      = 32;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_DEL  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;
    localparam logic [1:0] FUNC_LIST = 2'd3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [PAY_WORDS-1:0][WORD_W-1:0] t_pay;

    typedef struct packed {
        t_word key;
        t_pay  pay;
    } t_row;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_ctl;

endpackage

`default_nettype wire

>>> rtl/krt_if.sv
// Request and response channel interfaces of the keyed record table.
`default_nettype none

interface krt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    krt_pkg::t_word     key;
    krt_pkg::t_word     pay_a;
    krt_pkg::t_word     pay_b;
    krt_pkg::t_word     pay_c;
    krt_pkg::t_word     pay_d;
    krt_pkg::t_word     pay_e;
    krt_pkg::t_word     pay_f;
    krt_pkg::t_word     pay_g;

    modport source (output valid, func, key, pay_a, pay_b, pay_c, pay_d, pay_e, pay_f, pay_g,
                    input ready);
    modport sink   (input valid, func, key, pay_a, pay_b, pay_c, pay_d, pay_e, pay_f, pay_g,
                    output ready);
endinterface

interface krt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [krt_pkg::CNT_W-1:0]   entry_total;
    krt_pkg::t_word              out_key;
    krt_pkg::t_word              out_a;
    krt_pkg::t_word              out_b;
    krt_pkg::t_word              out_c;
    krt_pkg::t_word              out_d;
    krt_pkg::t_word              out_e;
    krt_pkg::t_word              out_f;
    krt_pkg::t_word              out_g;
    logic                        last;

    modport source (output valid, ok, entry_total, out_key, out_a, out_b, out_c, out_d,
                    out_e, out_f, out_g, last, input ready);
    modport sink   (input valid, ok, entry_total, out_key, out_a, out_b, out_c, out_d,
                    out_e, out_f, out_g, last, output ready);
endinterface

`default_nettype wire

>>> rtl/krt_row_mem.sv
// Row memory: one key and its payload words per row, one write and one read port.
`default_nettype none

module krt_row_mem (
    input  wire                i_clk,
    input  krt_pkg::t_mem_ctl  i_ctl,
    input  krt_pkg::t_row      i_wdata,
    output krt_pkg::t_row      o_rdata
);

    krt_pkg::t_row r_mem [krt_pkg::TABLE_DEPTH];
    krt_pkg::t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_ctl.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/keyed_record_table.sv
// Keyed record table: packed table of keyed records with add, delete, read and list.
//
// i_req carries one request: func, key and seven payload words (payload used by add).
// o_rsp returns one result per request, or one per live key for a list request,
// the final one flagged by last; entry_total is the live count after the request.
// Requests are taken one at a time; the rows sit in a single-port-read row memory
// with a registered read port, and that read port shapes each request:
//   add:    the row is written at the live count, then the result is emitted.
//   read:   rows are searched from the first (one row compared per cycle).
//   delete: search, then one row moved down per cycle.
//   list:   each live key is read, then emitted; an empty table gives one result.
// The result sits in an output register, so the next request is taken while a
// result still waits; a stalled receiver holds the result and, during a list or
// once the next result is ready, holds the sequencer.
// Synchronous reset (i_rst_n low) empties the table and drops any pending result;
// row contents are not cleared, since only rows below the live count are read.
`default_nettype none

module keyed_record_table (
    input  wire         i_clk,
    input  wire         i_rst_n,
    krt_req_if.sink     i_req,
    krt_rsp_if.source   o_rsp
);

    localparam int IDX_W = krt_pkg::IDX_W;
    localparam int CNT_W = krt_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ADD     = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_SHIFT   = 3'd3;
    localparam logic [2:0] ST_LIST_RD = 3'd4;
    localparam logic [2:0] ST_LIST_WR = 3'd5;
    localparam logic [2:0] ST_EMIT    = 3'd6;

    // control
    logic [2:0]        r_state,     n_state;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [CNT_W-1:0]  r_rd_idx,    n_rd_idx;
    logic              r_pend,      n_pend;
    logic [IDX_W-1:0]  r_pend_idx,  n_pend_idx;
    logic              r_out_valid, n_out_valid;

    // request and result data
    logic [1:0]        r_func,      n_func;
    krt_pkg::t_word    r_key,       n_key;
    krt_pkg::t_pay     r_pay,       n_pay;
    logic              r_res_ok,    n_res_ok;
    krt_pkg::t_word    r_res_key,   n_res_key;
    krt_pkg::t_pay     r_res_pay,   n_res_pay;

    // output register
    logic              r_o_ok,      n_o_ok;
    logic [CNT_W-1:0]  r_o_total,   n_o_total;
    krt_pkg::t_word    r_o_key,     n_o_key;
    krt_pkg::t_pay     r_o_pay,     n_o_pay;
    logic              r_o_last,    n_o_last;

    krt_pkg::t_mem_ctl mem_ctl;
    krt_pkg::t_row     mem_wdata;
    krt_pkg::t_row     rd_row;

    logic slot_free;
    logic hit;
    logic issue_ok;
    logic list_last;

    krt_row_mem u_row_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_wdata (mem_wdata),
        .o_rdata (rd_row)
    );

    assign slot_free = !r_out_valid || o_rsp.ready;
    assign hit       = r_pend && (rd_row.key == r_key);
    assign issue_ok  = r_rd_idx < r_count;
    assign list_last = (r_rd_idx + CNT_W'(1)) == r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_func      = r_func;
        n_key       = r_key;
        n_pay       = r_pay;
        n_res_ok    = r_res_ok;
        n_res_key   = r_res_key;
        n_res_pay   = r_res_pay;
        n_o_ok      = r_o_ok;
        n_o_total   = r_o_total;
        n_o_key     = r_o_key;
        n_o_pay     = r_o_pay;
        n_o_last    = r_o_last;

        mem_ctl.we    = 1'b0;
        mem_ctl.waddr = r_count[IDX_W-1:0];
        mem_ctl.re    = 1'b0;
        mem_ctl.raddr = r_rd_idx[IDX_W-1:0];
        mem_wdata.key = r_key;
        mem_wdata.pay = r_pay;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_func    = i_req.func;
                    n_key     = i_req.key;
                    n_pay     = {i_req.pay_g, i_req.pay_f, i_req.pay_e, i_req.pay_d,
                                 i_req.pay_c, i_req.pay_b, i_req.pay_a};
                    n_rd_idx  = '0;
                    n_pend    = 1'b0;
                    n_res_ok  = 1'b0;
                    n_res_key = '0;
                    n_res_pay = '0;
                    case (i_req.func)
                        krt_pkg::FUNC_ADD:  n_state = ST_ADD;
                        krt_pkg::FUNC_DEL:  n_state = ST_SCAN;
                        krt_pkg::FUNC_READ: n_state = ST_SCAN;
                        krt_pkg::FUNC_LIST: n_state = (r_count == '0) ? ST_EMIT : ST_LIST_RD;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end

            ST_ADD: begin
                if (r_count != CNT_W'(krt_pkg::TABLE_DEPTH)) begin
                    mem_ctl.we = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                    n_res_ok   = 1'b1;
                end
                n_state = ST_EMIT;
            end

            // one row read issued and one compared per cycle
            ST_SCAN: begin
                mem_ctl.re = issue_ok && !hit;
                if (issue_ok) begin
                    n_rd_idx   = r_rd_idx + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (hit) begin
                    n_pend = 1'b0;
                    if (r_func == krt_pkg::FUNC_READ) begin
                        n_res_ok  = 1'b1;
                        n_res_key = rd_row.key;
                        n_res_pay = rd_row.pay;
                        n_state   = ST_EMIT;
                    end else begin
                        n_rd_idx = CNT_W'(r_pend_idx) + CNT_W'(1);
                        n_state  = ST_SHIFT;
                    end
                end else if (!issue_ok) begin
                    n_state = ST_EMIT;
                end
            end

            // read row i+1 while row i-1's successor is written one place down
            ST_SHIFT: begin
                mem_ctl.re = issue_ok;
                if (issue_ok) begin
                    n_rd_idx   = r_rd_idx + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = r_pend_idx - IDX_W'(1);
                    mem_wdata     = rd_row;
                end
                if (!issue_ok && !r_pend) begin
                    n_count  = r_count - CNT_W'(1);
                    n_res_ok = 1'b1;
                    n_state  = ST_EMIT;
                end
            end

            ST_LIST_RD: begin
                mem_ctl.re = 1'b1;
                n_state    = ST_LIST_WR;
            end

            ST_LIST_WR: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_o_ok      = 1'b1;
                    n_o_total   = r_count;
                    n_o_key     = rd_row.key;
                    n_o_pay     = '0;
                    n_o_last    = list_last;
                    if (list_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + CNT_W'(1);
                        n_state  = ST_LIST_RD;
                    end
                end
            end

            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_o_ok      = r_res_ok;
                    n_o_total   = r_count;
                    n_o_key     = r_res_key;
                    n_o_pay     = r_res_pay;
                    n_o_last    = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_pend_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_pend_idx  <= n_pend_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_key     <= n_key;
        r_pay     <= n_pay;
        r_res_ok  <= n_res_ok;
        r_res_key <= n_res_key;
        r_res_pay <= n_res_pay;
        r_o_ok    <= n_o_ok;
        r_o_total <= n_o_total;
        r_o_key   <= n_o_key;
        r_o_pay   <= n_o_pay;
        r_o_last  <= n_o_last;
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_o_ok;
    assign o_rsp.entry_total = r_o_total;
    assign o_rsp.out_key     = r_o_key;
    assign o_rsp.out_a       = r_o_pay[0];
    assign o_rsp.out_b       = r_o_pay[1];
    assign o_rsp.out_c       = r_o_pay[2];
    assign o_rsp.out_d       = r_o_pay[3];
    assign o_rsp.out_e       = r_o_pay[4];
    assign o_rsp.out_f       = r_o_pay[5];
    assign o_rsp.out_g       = r_o_pay[6];
    assign o_rsp.last        = r_o_last;

endmodule

`default_nettype wire
